FILE: rtl/core/sha1_message_padder_unit_assert.svh
// Assertion macros shared by the SHA-1 message padder RTL.
`ifndef SHA1_MESSAGE_PADDER_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_PADDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sha1 padder assertion failed");
`define SMP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("sha1 padder assertion failed");
`else
`define SMP_ASSERT(lbl, clk, rst_n, prop)
`define SMP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/smp_pkg.sv
// Shared constants and controller/datapath interface types for the SHA-1 padder.
`default_nettype none
package smp_pkg;

    localparam int unsigned COUNT_W = 61;
    localparam int unsigned ACC_W   = 24;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] PAD_MARKER = 8'h80;
    localparam logic [IDX_W-1:0]  LEN_HI_IDX = 4'd14;
    localparam logic [IDX_W-1:0]  LEN_LO_IDX = 4'd15;

    typedef struct packed {
        logic load_byte;
        logic start_flush;
        logic emit_pad;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic final_word;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/core/smp_datapath.sv
// Datapath of the SHA-1 padder: byte packing, padding words and output register.
`default_nettype none
`include "sha1_message_padder_unit_assert.svh"
module smp_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire smp_pkg::t_dp_cmd                 i_cmd,
    output smp_pkg::t_dp_status                   o_status,
    input  wire logic [smp_pkg::BYTE_W-1:0]       i_byte,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [smp_pkg::WORD_W-1:0]            o_word,
    output logic [smp_pkg::IDX_W-1:0]             o_word_idx,
    output logic                                  o_block_last,
    output logic                                  o_msg_last
);

    logic [smp_pkg::COUNT_W-1:0] r_count, n_count;
    logic [smp_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [smp_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_len_blk, n_len_blk;
    logic                        r_valid, n_valid;
    logic [smp_pkg::WORD_W-1:0]  r_word, n_word;
    logic [smp_pkg::IDX_W-1:0]   r_widx, n_widx;
    logic                        r_mlast, n_mlast;

    logic [smp_pkg::IDX_W-1:0]   w_cur_idx;
    logic [smp_pkg::WORD_W-1:0]  w_marker_word;
    logic [smp_pkg::WORD_W-1:0]  w_pad_word;
    logic                        w_final;

    assign w_cur_idx = r_count[5:2];
    assign w_final   = r_len_blk && (r_idx == smp_pkg::LEN_LO_IDX);

    // The marker lands right after the bytes already held in the accumulator.
    always_comb begin
        case (r_count[1:0])
            2'd0:    w_marker_word = {smp_pkg::PAD_MARKER, 24'h000000};
            2'd1:    w_marker_word = {r_acc[7:0], smp_pkg::PAD_MARKER, 16'h0000};
            2'd2:    w_marker_word = {r_acc[15:0], smp_pkg::PAD_MARKER, 8'h00};
            2'd3:    w_marker_word = {r_acc, smp_pkg::PAD_MARKER};
            default: w_marker_word = '0;
        endcase
    end

    // The bit length is the byte count shifted left by three.
    always_comb begin
        if (r_len_blk && (r_idx == smp_pkg::LEN_HI_IDX)) begin
            w_pad_word = r_count[60:29];
        end else if (r_len_blk && (r_idx == smp_pkg::LEN_LO_IDX)) begin
            w_pad_word = {r_count[28:0], 3'b000};
        end else begin
            w_pad_word = '0;
        end
    end

    always_comb begin
        n_count   = r_count;
        n_acc     = r_acc;
        n_idx     = r_idx;
        n_len_blk = r_len_blk;
        n_valid   = r_valid && !i_out_ready;
        n_word    = r_word;
        n_widx    = r_widx;
        n_mlast   = r_mlast;
        if (i_cmd.load_byte) begin
            n_count = r_count + 61'd1;
            if (r_count[1:0] == 2'd3) begin
                n_valid = 1'b1;
                n_word  = {r_acc, i_byte};
                n_widx  = w_cur_idx;
                n_mlast = 1'b0;
                n_acc   = '0;
            end else begin
                n_acc = {r_acc[15:0], i_byte};
            end
        end else if (i_cmd.start_flush) begin
            n_valid   = 1'b1;
            n_word    = w_marker_word;
            n_widx    = w_cur_idx;
            n_mlast   = 1'b0;
            n_acc     = '0;
            n_idx     = w_cur_idx + 4'd1;
            // Only a marker in word 14 pushes the length into a block that still has to
            // finish this one first; a marker in word 15 wraps straight into the new block.
            n_len_blk = (w_cur_idx != smp_pkg::LEN_HI_IDX);
        end else if (i_cmd.emit_pad) begin
            n_valid = 1'b1;
            n_word  = w_pad_word;
            n_widx  = r_idx;
            n_mlast = w_final;
            n_idx   = r_idx + 4'd1;
            if (r_idx == smp_pkg::LEN_LO_IDX) begin
                n_len_blk = 1'b1;
            end
            if (w_final) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_acc     <= '0;
            r_idx     <= '0;
            r_len_blk <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_acc     <= n_acc;
            r_idx     <= n_idx;
            r_len_blk <= n_len_blk;
            r_valid   <= n_valid;
        end
        r_word  <= n_word;
        r_widx  <= n_widx;
        r_mlast <= n_mlast;
    end

    assign o_status = '{out_free: (!r_valid || i_out_ready), final_word: w_final};
    assign o_out_valid  = r_valid;
    assign o_word       = r_word;
    assign o_word_idx   = r_widx;
    assign o_block_last = (r_widx == smp_pkg::LEN_LO_IDX);
    assign o_msg_last   = r_mlast;

    `SMP_ASSERT(a_mlast_ends_block, i_clk, i_rst_n, (r_valid && r_mlast) |-> (r_widx == smp_pkg::LEN_LO_IDX))
    `SMP_ASSERT(a_final_clears_count, i_clk, i_rst_n, (i_cmd.emit_pad && w_final) |=> (r_count == '0))
    `SMP_ASSERT(a_cmd_needs_room, i_clk, i_rst_n, (i_cmd.load_byte || i_cmd.start_flush || i_cmd.emit_pad) |-> (!r_valid || i_out_ready))
    `SMP_ASSERT(a_flush_empties_acc, i_clk, i_rst_n, i_cmd.start_flush |=> (r_acc == '0))

endmodule
`default_nettype wire

FILE: rtl/core/smp_ctrl.sv
// Controller of the SHA-1 padder: input acceptance and padding flush sequencing.
`default_nettype none
`include "sha1_message_padder_unit_assert.svh"
module smp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_end,
    output logic                      o_in_ready,
    input  wire smp_pkg::t_dp_status  i_status,
    output smp_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_end) begin
                        o_cmd.start_flush = 1'b1;
                        n_state           = ST_FLUSH;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_pad = 1'b1;
                    if (i_status.final_word) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SMP_ASSERT(a_end_starts_flush, i_clk, i_rst_n, (w_accept && i_in_end) |=> (r_state == ST_FLUSH))

endmodule
`default_nettype wire

FILE: rtl/core/sha1_message_padder_unit.sv
// Top level of the SHA-1 message padder: byte stream in, padded 32-bit block words out.
//
// Usage: message bytes arrive on the slave channel, one per request, with tlast low.
// A request with tlast high ends the message; its tdata is ignored. Every fourth byte
// produces one word on the master channel, first byte in bits 31..24, with the word's
// position in the 64-byte block in tuser[3:0] and a block-end flag in tuser[4].
// The end request produces 3 to 18 words: the 0x80 marker, zero fill and the 64-bit
// big-endian bit length; the last of them carries tlast.
// A completed word is registered and appears in the cycle after the request that completes it.
// Throughput: one byte per cycle while the master side keeps up; during the end
// request's flush the controller fills the single output register once per cycle,
// again only while the master side keeps up.
// A single output register separates the channels: a new byte is taken while a word
// waits, as long as the receiver takes it in the same cycle. When the receiver stalls,
// the slave side is held off and the pending word stays unchanged.
// Synchronous reset clears the byte count, the partial word and the output valid.
`default_nettype none
module sha1_message_padder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,   // end_of_message
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] word_value
    output logic [4:0]       o_m_axis_tuser,   // [3:0] word_index, [4] block_last
    output logic             o_m_axis_tlast    // message_last
);

    smp_pkg::t_dp_cmd    w_cmd;
    smp_pkg::t_dp_status w_status;
    logic [3:0]          w_word_idx;
    logic                w_block_last;

    smp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_end   (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    smp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_byte       (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_word       (o_m_axis_tdata),
        .o_word_idx   (w_word_idx),
        .o_block_last (w_block_last),
        .o_msg_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {w_block_last, w_word_idx};

endmodule
`default_nettype wire

FILE: bench/tb_sha1_message_padder_unit.sv
// Self-checking testbench for the SHA-1 message padder: random byte streams in, predicted words out.
`default_nettype none
module tb_sha1_message_padder_unit;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned HOLD_AFTER  = 200;
    localparam int unsigned RAND_ITEMS  = 500;
    localparam logic [5:0]  LENGTH_POS  = 6'd56;

    typedef struct {
        logic [7:0] data;
        logic        eom;
        bit          drain;   // wait for every word to come out before offering this byte
    } t_msg_byte;

    typedef struct {
        logic [smp_pkg::WORD_W-1:0] value;
        logic [smp_pkg::IDX_W-1:0]  index;
        logic                       block_end;
        logic                       msg_end;
    } t_block_word;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;
    wire  [4:0]  o_m_axis_tuser;
    wire         o_m_axis_tlast;

    t_msg_byte   bytes_pending[$];
    t_block_word words_due[$];

    logic [smp_pkg::COUNT_W-1:0] msg_bytes = '0;
    logic [smp_pkg::ACC_W-1:0]   word_acc = '0;

    int unsigned err_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 100;
    bit          hold_done = 1'b0;
    logic        hold_on = 1'b0;
    logic        quiet_mode = 1'b0;
    logic        s_taken = 1'b0;

    sha1_message_padder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none at all while the quiet stretch lasts.
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_mode) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_cnt++;
        if (err_cnt <= 50)
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    // Shift one byte into the partial word; a fourth byte completes a word.
    task automatic shift_in(input logic [7:0] b, input logic [5:0] pos, input logic fin);
        t_block_word w;
        if (pos[1:0] == 2'b11) begin
            w.value     = {word_acc, b};
            w.index     = pos[5:2];
            w.block_end = (pos[5:2] == 4'd15);
            w.msg_end   = fin;
            words_due.push_back(w);
            word_acc = '0;
        end else begin
            word_acc = {word_acc[15:0], b};
        end
    endtask

    task automatic predict_words(input logic [7:0] b, input logic eom);
        logic [63:0] bit_len;
        logic [5:0]  pos;
        if (!eom) begin
            shift_in(b, msg_bytes[5:0], 1'b0);
            msg_bytes = msg_bytes + 1'b1;
        end else begin
            bit_len = {msg_bytes, 3'b000};
            pos = msg_bytes[5:0];
            shift_in(smp_pkg::PAD_MARKER, pos, 1'b0);
            pos = pos + 6'd1;
            while (pos != LENGTH_POS) begin
                shift_in(8'h00, pos, 1'b0);
                pos = pos + 6'd1;
            end
            for (int i = 0; i < 8; i++) begin
                shift_in(bit_len[63-8*i -: 8], pos, i == 7);
                pos = pos + 6'd1;
            end
            msg_bytes = '0;
            word_acc = '0;
        end
    endtask

    task automatic queue_message(input int unsigned len, input logic [7:0] end_data,
                                 input bit drain);
        t_msg_byte it;
        for (int unsigned k = 0; k < len; k++) begin
            it.data  = 8'($urandom_range(0, 255));
            it.eom   = 1'b0;
            it.drain = drain && (k == 0);
            bytes_pending.push_back(it);
        end
        it.data  = end_data;
        it.eom   = 1'b1;
        it.drain = drain && (len == 0);
        bytes_pending.push_back(it);
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic eom, input bit drain);
        t_msg_byte it;
        it.data  = d;
        it.eom   = eom;
        it.drain = drain;
        bytes_pending.push_back(it);
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned special_len[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        // Empty message, with junk on the data lines of the end request.
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        queue_byte(8'h01, 1'b0, 1'b0);
        queue_byte(8'h7F, 1'b0, 1'b0);
        queue_byte(8'hAA, 1'b0, 1'b0);
        queue_byte(8'h5A, 1'b1, 1'b0);
        queue_byte(8'h55, 1'b0, 1'b0);
        queue_byte(8'hC3, 1'b0, 1'b0);
        queue_byte(8'h3C, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_message(0, 8'h00, 1'b1);
        while (bytes_pending.size() < 14 + RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(0, 20);
            else if (pick < 8)
                len = $urandom_range(21, 70);
            else if (pick == 8)
                len = special_len[3'($urandom_range(0, 7))];
            else
                len = 0;
            queue_message(len, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        while (bytes_pending.size() != 0 || s_tvalid || words_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[sha1_message_padder_unit] OK");
        end else begin
            $display("[sha1_message_padder_unit] ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            quiet_mode <= ~quiet_mode;
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
    end

    // Byte sender: a request stays up until it is taken; the next one follows a gap, possibly none.
    always @(negedge i_clk) begin
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        t_msg_byte  it;
        nv = s_tvalid;
        nd = s_tdata;
        nl = s_tlast;
        if (rst_n && (!s_tvalid || s_taken)) begin
            nv = 1'b0;
            if (send_gap != 0 && !hold_on) begin
                send_gap = send_gap - 1;
            end else if (bytes_pending.size() != 0 &&
                         !(bytes_pending[0].drain && words_due.size() != 0)) begin
                it = bytes_pending.pop_front();
                nv = 1'b1;
                nd = it.data;
                nl = it.eom;
                send_gap = next_gap();
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
        s_tlast  <= nl;
    end

    // Word receiver: random stalls, plus one long hold once the stream is well under way.
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b1;
        if (!hold_done && taken_cnt >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            nr = 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_stall != 0) begin
            nr = 1'b0;
            rx_stall = rx_stall - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_stall = next_gap();
        end
        hold_on  <= (hold_left != 0);
        m_tready <= rst_n && nr;
    end

    always @(posedge i_clk) begin
        t_block_word w;
        logic        in_fire;
        logic        out_fire;
        if (rst_n) begin
            in_fire  = s_tvalid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && m_tready;
            if (out_fire) begin
                if (words_due.size() == 0) begin
                    report_mismatch("unexpected word", {32'h0, o_m_axis_tdata}, 64'h0);
                end else begin
                    w = words_due.pop_front();
                    if (o_m_axis_tdata !== w.value)
                        report_mismatch("word_value", 64'(o_m_axis_tdata), 64'(w.value));
                    if (o_m_axis_tuser[3:0] !== w.index)
                        report_mismatch("word_index", 64'(o_m_axis_tuser[3:0]),
                                        64'(w.index));
                    if (o_m_axis_tuser[4] !== w.block_end)
                        report_mismatch("block_last", 64'(o_m_axis_tuser[4]),
                                        64'(w.block_end));
                    if (o_m_axis_tlast !== w.msg_end)
                        report_mismatch("message_last", 64'(o_m_axis_tlast),
                                        64'(w.msg_end));
                end
            end
            if (in_fire) begin
                predict_words(s_tdata, s_tlast);
                taken_cnt <= taken_cnt + 1;
            end
            s_taken <= in_fire;
            if (in_fire || out_fire) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[sha1_message_padder_unit] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
`default_nettype wire
